>>> hdl/cdm_pkg.sv
// Package with shared constants, types and lookup tables of the color dominance mask.
`default_nettype none

package cdm_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int MAX_BLOCK  = 16;

	// Position counters inside a block and the clamped block size.
	localparam int CNT_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int BSZ_W = CNT_W + 1;

	localparam int POS_W      = 16;
	localparam int BLK_W      = 5;
	localparam int PIX_W      = 16;
	localparam int ADDR_W     = 22;
	localparam int DIM_W      = 12;
	localparam int BRT_W      = 10;
	localparam int CH_W       = 8;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 12;

	localparam logic [CH_W-1:0] MASK_ON  = 8'd255;
	localparam logic [CH_W-1:0] MASK_OFF = 8'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH    = 4'd0,
		REG_IMAGE_HEIGHT   = 4'd1,
		REG_BRIGHTNESS_MIN = 4'd2,
		REG_CHANNEL_MIN    = 4'd3
	} cfg_reg_t;

	typedef logic [CH_W-1:0] exp5_lut_t [32];
	typedef logic [CH_W-1:0] exp6_lut_t [64];

	// Channel expansion with truncating division, evaluated at elaboration.
	function automatic exp5_lut_t exp5_table();
		exp5_lut_t t;
		for (int i = 0; i < 32; i++) begin
			t[i] = CH_W'((i * 255) / 31);
		end
		return t;
	endfunction

	function automatic exp6_lut_t exp6_table();
		exp6_lut_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = CH_W'((i * 255) / 63);
		end
		return t;
	endfunction

	localparam exp5_lut_t EXP5_LUT = exp5_table();
	localparam exp6_lut_t EXP6_LUT = exp6_table();

	// A block size of zero counts as one; sizes above MAX_BLOCK saturate at MAX_BLOCK.
	function automatic logic [BSZ_W-1:0] clamp_block(input logic [BLK_W-1:0] v);
		logic [BSZ_W-1:0] r;
		if (v == '0) begin
			r = BSZ_W'(1);
		end else if (int'(v) > MAX_BLOCK) begin
			r = BSZ_W'(MAX_BLOCK);
		end else begin
			r = BSZ_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/cdm_ifs.sv
// Handshake interfaces for the pixel input, mask output and configuration channels.
`default_nettype none

interface cdm_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] block_x;
	logic [15:0] block_y;
	logic [4:0]  block_w;
	logic [4:0]  block_h;
	logic [15:0] pixel;

	modport source (output valid, block_x, block_y, block_w, block_h, pixel, input ready);
	modport sink   (input valid, block_x, block_y, block_w, block_h, pixel, output ready);
endinterface

interface cdm_out_if;
	logic        valid;
	logic        ready;
	logic        write_enable;
	logic [21:0] address;
	logic [7:0]  mask_value;
	logic        block_end;

	modport source (output valid, write_enable, address, mask_value, block_end, input ready);
	modport sink   (input valid, write_enable, address, mask_value, block_end, output ready);
endinterface

interface cdm_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  reg_index;
	logic [11:0] wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

>>> hdl/rgb565_color_dominance_mask.sv
// RGB565 color dominance mask: top level with block walk, classifier and address unit.
//
// Usage: pix_in carries one RGB565 pixel per word together with the origin and
// size of its decoded block; pixels of a block come in raster order. mask_out
// returns one word per pixel: frame-buffer address, write enable (low when the
// pixel falls outside the frame), the mask value 255 or 0, and a block end flag
// on the last pixel of the block. cfg writes the frame width, frame height,
// brightness minimum and channel minimum by register index; it is always ready
// and must only be used while no pixel is in flight.
// A word accepted from pix_in is held in the input register, then in the result
// register, which drives mask_out. Throughput: one word per cycle while mask_out is
// ready; the 12x12 address multiplier between the two registers sets the clock period.
// When mask_out stalls, the result register holds its word and the input stage
// keeps taking one more word before pix_in.ready drops; no word is lost.
// Reset: the registers return to 320 x 240, brightness 80, channel 40, and the
// block position returns to the first pixel. No clearing pass is needed.
`default_nettype none

module rgb565_color_dominance_mask (
	input  wire        clk,
	input  wire        arst_n,
	cdm_cfg_if.sink    cfg,
	cdm_in_if.sink     pix_in,
	cdm_out_if.source  mask_out
);
	import cdm_pkg::*;

	logic [DIM_W-1:0]  image_width_q;
	logic [DIM_W-1:0]  image_height_q;
	logic [BRT_W-1:0]  brightness_min_q;
	logic [CH_W-1:0]   channel_min_q;

	logic [CNT_W-1:0]  col_count_q;
	logic [CNT_W-1:0]  row_count_q;

	logic              valid_s1;
	logic [POS_W:0]    ox_s1;
	logic [POS_W:0]    oy_s1;
	logic [PIX_W-1:0]  pixel_s1;
	logic              end_s1;

	logic              out_valid_q;
	logic              write_enable_q;
	logic [ADDR_W-1:0] address_q;
	logic [CH_W-1:0]   mask_value_q;
	logic              block_end_q;

	logic              adv_s2;
	logic              in_ready;
	logic              in_acc;
	logic [BSZ_W-1:0]  bw;
	logic [BSZ_W-1:0]  bh;
	logic              last_col;
	logic              last_row;
	logic              end_now;

	logic [DIM_W-1:0]   wid;
	logic [DIM_W-1:0]   hgt;
	logic               in_frame;
	logic [2*DIM_W-1:0] prod;
	logic [2*DIM_W:0]   addr_sum;
	logic [CH_W-1:0]    r8;
	logic [CH_W-1:0]    g8;
	logic [CH_W-1:0]    b8;
	logic [BRT_W-1:0]   bright;
	logic [10:0]        g5;
	logic [10:0]        r6;
	logic [10:0]        b6;
	logic [10:0]        b5;
	logic [11:0]        b10;
	logic [11:0]        g11;
	logic               green_dom;
	logic               blue_dom;
	logic               mask_on;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q    <= DIM_W'(320);
			image_height_q   <= DIM_W'(240);
			brightness_min_q <= BRT_W'(80);
			channel_min_q    <= CH_W'(40);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.reg_index)
				REG_IMAGE_WIDTH:    image_width_q    <= cfg.wr_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:   image_height_q   <= cfg.wr_data[DIM_W-1:0];
				REG_BRIGHTNESS_MIN: brightness_min_q <= cfg.wr_data[BRT_W-1:0];
				REG_CHANNEL_MIN:    channel_min_q    <= cfg.wr_data[CH_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves whenever the result register can take its word.
	assign adv_s2       = !out_valid_q || mask_out.ready;
	assign in_ready     = !valid_s1 || adv_s2;
	assign pix_in.ready = in_ready;
	assign in_acc       = pix_in.valid && in_ready;

	// Block walk. A count at or past a shrunken size ends the row or block.
	assign bw       = clamp_block(pix_in.block_w);
	assign bh       = clamp_block(pix_in.block_h);
	assign last_col = (BSZ_W'(col_count_q) + BSZ_W'(1)) >= bw;
	assign last_row = (BSZ_W'(row_count_q) + BSZ_W'(1)) >= bh;
	assign end_now  = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			row_count_q <= '0;
		end else if (in_acc) begin
			if (end_now) begin
				col_count_q <= '0;
				row_count_q <= '0;
			end else if (last_col) begin
				col_count_q <= '0;
				row_count_q <= row_count_q + CNT_W'(1);
			end else begin
				col_count_q <= col_count_q + CNT_W'(1);
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ox_s1    <= (POS_W+1)'(pix_in.block_x) + (POS_W+1)'(col_count_q);
			oy_s1    <= (POS_W+1)'(pix_in.block_y) + (POS_W+1)'(row_count_q);
			pixel_s1 <= pix_in.pixel;
			end_s1   <= end_now;
		end
	end

	// Frame bounds and address.
	assign wid = (int'(image_width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : image_width_q;
	assign hgt = (int'(image_height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : image_height_q;
	assign in_frame = (ox_s1 < (POS_W+1)'(wid)) && (oy_s1 < (POS_W+1)'(hgt));
	// Inside the frame the row is below the height, so its low bits are the whole row.
	assign prod     = oy_s1[DIM_W-1:0] * wid;
	assign addr_sum = (2*DIM_W+1)'(prod) + (2*DIM_W+1)'(ox_s1);

	// Classifier.
	assign r8     = EXP5_LUT[pixel_s1[15:11]];
	assign g8     = EXP6_LUT[pixel_s1[10:5]];
	assign b8     = EXP5_LUT[pixel_s1[4:0]];
	assign bright = BRT_W'(r8) + BRT_W'(g8) + BRT_W'(b8);
	assign g5     = 11'(g8) * 11'd5;
	assign r6     = 11'(r8) * 11'd6;
	assign b6     = 11'(b8) * 11'd6;
	assign b5     = 11'(b8) * 11'd5;
	assign b10    = 12'(b8) * 12'd10;
	assign g11    = 12'(g8) * 12'd11;

	assign green_dom = (g5 > r6) && (g5 > b6) && (g8 > channel_min_q);
	assign blue_dom  = (b5 > r6) && (b10 > g11) && (b8 > channel_min_q);
	assign mask_on   = (bright > brightness_min_q) && (green_dom || blue_dom);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			write_enable_q <= in_frame;
			address_q      <= in_frame ? addr_sum[ADDR_W-1:0] : '0;
			mask_value_q   <= mask_on ? MASK_ON : MASK_OFF;
			block_end_q    <= end_s1;
		end
	end

	assign mask_out.valid        = out_valid_q;
	assign mask_out.write_enable = write_enable_q;
	assign mask_out.address      = address_q;
	assign mask_out.mask_value   = mask_value_q;
	assign mask_out.block_end    = block_end_q;

`ifndef ASSERT_OFF
	a_addr_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (write_enable_q || address_q == '0))
		else $error("address not zero for a pixel outside the frame");

	a_mask_levels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (mask_value_q == MASK_ON || mask_value_q == MASK_OFF))
		else $error("mask value is neither on nor off");

	a_block_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && end_now) |=> (col_count_q == '0 && row_count_q == '0))
		else $error("block position not cleared after the last pixel");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> valid_s1)
		else $error("input stage word dropped while the result register stalled");
`endif

endmodule

`default_nettype wire
